/* hdl/s3tc_pkg.sv */
// Shared types, constants and register codes for the S3TC block decoder.
package s3tc_pkg;

    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 32;
    localparam int InDataW  = 128;
    localparam int OutDataW = 40;

    // Register index decoded from the word address.
    localparam logic REG_FORMAT = 1'b0;

    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;

    // Reciprocal multipliers for exact truncating division on bounded values.
    localparam logic [9:0]  RECIP3 = 10'd683;   // x <= 765, shift 11
    localparam logic [11:0] RECIP7 = 12'd2341;  // x <= 1785, shift 14
    localparam logic [11:0] RECIP5 = 12'd3277;  // x <= 1275, shift 14

    typedef struct packed {
        logic [1:0]  fmt;
        logic [63:0] alpha_block;
        logic [63:0] color_block;
    } blk_t;

    typedef struct packed {
        logic [1:0]        fmt;
        logic [63:0]       alpha_block;
        logic [31:0]       cidx;
        logic              c_four;
        logic [2:0][7:0]   p0;
        logic [2:0][7:0]   p1;
        logic [2:0][9:0]   s_hi;
        logic [2:0][9:0]   s_lo;
        logic [2:0][8:0]   mid;
        logic              a_gt;
        logic [7:0]        a0;
        logic [7:0]        a1;
        logic [5:0][10:0]  a7;
        logic [3:0][10:0]  a5;
    } sums_t;

    typedef struct packed {
        logic [1:0]           fmt;
        logic [63:0]          alpha_block;
        logic [31:0]          cidx;
        logic                 c_four;
        logic [3:0][2:0][7:0] crgb;
        logic [7:0][7:0]      apal;
    } pal_t;

endpackage

/* hdl/s3tc_pal_sum.sv */
// Pipeline stage: endpoint expansion and weighted palette sums.
module s3tc_pal_sum import s3tc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  blk_t  in_blk,
    output logic  out_valid,
    input  logic  out_ready,
    output sums_t out_sums
);

    logic  valid_reg;
    sums_t sums_reg;
    sums_t sums_next;

    logic [15:0] c0;
    logic [15:0] c1;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_sums  = sums_reg;

    always_comb begin
        c0 = in_blk.color_block[15:0];
        c1 = in_blk.color_block[31:16];
        sums_next.fmt         = in_blk.fmt;
        sums_next.alpha_block = in_blk.alpha_block;
        sums_next.cidx        = in_blk.color_block[63:32];
        sums_next.c_four      = (in_blk.fmt != FMT_DXT1) || (c0 > c1);
        // Bit replication: red and blue are 5 bits, green is 6 bits.
        sums_next.p0[0] = {c0[15:11], c0[15:13]};
        sums_next.p0[1] = {c0[10:5], c0[10:9]};
        sums_next.p0[2] = {c0[4:0], c0[4:2]};
        sums_next.p1[0] = {c1[15:11], c1[15:13]};
        sums_next.p1[1] = {c1[10:5], c1[10:9]};
        sums_next.p1[2] = {c1[4:0], c1[4:2]};
        for (int ch = 0; ch < 3; ch++) begin
            sums_next.s_hi[ch] = {1'b0, sums_next.p0[ch], 1'b0} + {2'b0, sums_next.p1[ch]};
            sums_next.s_lo[ch] = {2'b0, sums_next.p0[ch]} + {1'b0, sums_next.p1[ch], 1'b0};
            sums_next.mid[ch]  = {1'b0, sums_next.p0[ch]} + {1'b0, sums_next.p1[ch]};
        end
        sums_next.a0   = in_blk.alpha_block[7:0];
        sums_next.a1   = in_blk.alpha_block[15:8];
        sums_next.a_gt = sums_next.a0 > sums_next.a1;
        for (int j = 0; j < 6; j++) begin
            sums_next.a7[j] = 11'(6 - j) * {3'b0, sums_next.a0}
                            + 11'(j + 1) * {3'b0, sums_next.a1};
        end
        for (int j = 0; j < 4; j++) begin
            sums_next.a5[j] = 11'(4 - j) * {3'b0, sums_next.a0}
                            + 11'(j + 1) * {3'b0, sums_next.a1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            sums_reg <= sums_next;
        end
    end

endmodule

/* hdl/s3tc_pal_div.sv */
// Pipeline stage: reciprocal division and palette selection.
module s3tc_pal_div import s3tc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  sums_t in_sums,
    output logic  out_valid,
    input  logic  out_ready,
    output pal_t  out_pal
);

    logic valid_reg;
    pal_t pal_reg;
    pal_t pal_next;

    logic [19:0] prod_hi [3];
    logic [19:0] prod_lo [3];
    logic [22:0] prod7 [6];
    logic [22:0] prod5 [4];

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_pal   = pal_reg;

    always_comb begin
        pal_next.fmt         = in_sums.fmt;
        pal_next.alpha_block = in_sums.alpha_block;
        pal_next.cidx        = in_sums.cidx;
        pal_next.c_four      = in_sums.c_four;
        for (int ch = 0; ch < 3; ch++) begin
            prod_hi[ch] = {10'b0, in_sums.s_hi[ch]} * {10'b0, RECIP3};
            prod_lo[ch] = {10'b0, in_sums.s_lo[ch]} * {10'b0, RECIP3};
            pal_next.crgb[0][ch] = in_sums.p0[ch];
            pal_next.crgb[1][ch] = in_sums.p1[ch];
            if (in_sums.c_four) begin
                pal_next.crgb[2][ch] = prod_hi[ch][18:11];
                pal_next.crgb[3][ch] = prod_lo[ch][18:11];
            end else begin
                pal_next.crgb[2][ch] = in_sums.mid[ch][8:1];
                pal_next.crgb[3][ch] = 8'd0;
            end
        end
        for (int j = 0; j < 6; j++) begin
            prod7[j] = {12'b0, in_sums.a7[j]} * {11'b0, RECIP7};
        end
        for (int j = 0; j < 4; j++) begin
            prod5[j] = {12'b0, in_sums.a5[j]} * {11'b0, RECIP5};
        end
        pal_next.apal[0] = in_sums.a0;
        pal_next.apal[1] = in_sums.a1;
        if (in_sums.a_gt) begin
            for (int j = 0; j < 6; j++) begin
                pal_next.apal[j + 2] = prod7[j][21:14];
            end
        end else begin
            for (int j = 0; j < 4; j++) begin
                pal_next.apal[j + 2] = prod5[j][21:14];
            end
            pal_next.apal[6] = 8'h00;
            pal_next.apal[7] = 8'hFF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pal_reg <= pal_next;
        end
    end

endmodule

/* hdl/s3tc_texel_ser.sv */
// Texel serializer: walks the sixteen texels of a block into the output register.
module s3tc_texel_ser import s3tc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  pal_t        in_pal,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic        m_tlast
);

    logic       blk_valid_reg;
    pal_t       pal_reg;
    logic [3:0] cnt_reg;
    logic [3:0] cnt_next;

    logic       out_valid_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] alpha_reg;
    logic [3:0] index_reg;
    logic       last_reg;

    logic       advance;
    logic       blk_done;
    logic [1:0] ci;
    logic [5:0] abase;
    logic [3:0] a4;
    logic [7:0] alpha_sel;

    assign advance  = blk_valid_reg && (!out_valid_reg || m_tready);
    assign blk_done = advance && (cnt_reg == 4'hF);
    assign in_ready = !blk_valid_reg || blk_done;
    assign cnt_next = cnt_reg + 4'd1;

    always_comb begin
        ci    = pal_reg.cidx[{cnt_reg, 1'b0} +: 2];
        abase = 6'd16 + {2'b0, cnt_reg} + {1'b0, cnt_reg, 1'b0};
        a4    = pal_reg.alpha_block[{cnt_reg, 2'b00} +: 4];
        case (pal_reg.fmt)
            FMT_DXT1: begin
                alpha_sel = (ci == 2'd3 && !pal_reg.c_four) ? 8'h00 : 8'hFF;
            end
            FMT_DXT3: begin
                alpha_sel = {a4, a4};
            end
            default: begin
                alpha_sel = pal_reg.apal[pal_reg.alpha_block[abase +: 3]];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_valid_reg <= 1'b0;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                blk_valid_reg <= in_valid;
                cnt_reg       <= 4'd0;
            end else if (advance) begin
                cnt_reg <= cnt_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pal_reg <= in_pal;
        end
        if (advance) begin
            red_reg   <= pal_reg.crgb[ci][0];
            green_reg <= pal_reg.crgb[ci][1];
            blue_reg  <= pal_reg.crgb[ci][2];
            alpha_reg <= alpha_sel;
            index_reg <= cnt_reg;
            last_reg  <= (cnt_reg == 4'hF);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, index_reg, alpha_reg, blue_reg, green_reg, red_reg};
    assign m_tlast  = last_reg;

endmodule

/* hdl/s3tc_block_decoder_unit.sv */
// Top level of the S3TC block decoder: configuration port, input stage, pipeline.
//
//  Channel   Direction  Transfer contents
//  s_        in         one compressed block: color half, alpha half
//  m_        out        one RGBA texel with its index; tlast on the sixteenth
//  APB       in/out     format register at byte address 0
//
// A block yields sixteen texels at one texel per cycle while m_ does not stall;
// the texel serializer takes the next block as it emits the last texel of one.
// The first texel passes the input, sum, division, block and output registers.
// Synchronous reset clears all valid bits and sets the format to DXT1.
// Stalls on m_ hold the output register; the stages before it fill and then
// deassert s_tready without losing or repeating a block.
module s3tc_block_decoder_unit import s3tc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // APB configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [CfgDataW-1:0] pwdata,
    output logic [CfgDataW-1:0] prdata,
    output logic                pready,
    // Input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,   // color_block[63:0], alpha_block[127:64]
    // Output stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,   // red, green, blue, alpha_value, texel_index, pad
    output logic                m_tlast
);

    logic [1:0] format_reg;
    logic       cfg_write;

    logic  in_valid_reg;
    blk_t  blk_reg;
    logic  sum_ready;
    logic  sum_valid;
    sums_t sums;
    logic  div_ready;
    logic  div_valid;
    pal_t  pal;
    logic  ser_ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_FORMAT);
    assign prdata    = (paddr[2] == REG_FORMAT) ? {30'b0, format_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg <= FMT_DXT1;
        end else if (cfg_write) begin
            format_reg <= pwdata[1:0];
        end
    end

    assign s_tready = !in_valid_reg || sum_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            blk_reg.color_block <= s_tdata[63:0];
            blk_reg.alpha_block <= s_tdata[127:64];
            blk_reg.fmt         <= format_reg;
        end
    end

    s3tc_pal_sum u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_ready  (sum_ready),
        .in_blk    (blk_reg),
        .out_valid (sum_valid),
        .out_ready (div_ready),
        .out_sums  (sums)
    );

    s3tc_pal_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sum_valid),
        .in_ready  (div_ready),
        .in_sums   (sums),
        .out_valid (div_valid),
        .out_ready (ser_ready),
        .out_pal   (pal)
    );

    s3tc_texel_ser u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (div_valid),
        .in_ready (ser_ready),
        .in_pal   (pal),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
